@@ rtl/sit_pkg.sv @@
`timescale 1ns / 1ps
package sit_pkg;
    localparam int DEPTH    = 32;
    localparam int KEY_BITS = 16;
    localparam int IDX_W    = $clog2(DEPTH);
    localparam int CNT_W    = IDX_W + 1;
    localparam int REC_W    = 5;
    localparam int ENT_W    = KEY_BITS + REC_W + 1;

    localparam logic [1:0] FN_INSERT = 2'd0;
    localparam logic [1:0] FN_LOOKUP = 2'd1;
    localparam logic [1:0] FN_DELETE = 2'd2;
    localparam logic [1:0] FN_UNUSED = 2'd3;

    localparam logic [1:0] ST_OK        = 2'd0;
    localparam logic [1:0] ST_NOT_FOUND = 2'd1;
    localparam logic [1:0] ST_FULL      = 2'd2;
    localparam logic [1:0] ST_DUP       = 2'd3;

    typedef struct packed {
        logic [KEY_BITS-1:0] key;
        logic [REC_W-1:0]    rec;
        logic                deleted;
    } entry_t;

    typedef enum logic [8:0] {
        S_IDLE   = 9'b000000001,
        S_RD     = 9'b000000010,
        S_CHK    = 9'b000000100,
        S_DECIDE = 9'b000001000,
        S_SHRD   = 9'b000010000,
        S_SHWR   = 9'b000100000,
        S_WRNEW  = 9'b001000000,
        S_WRDEL  = 9'b010000000,
        S_DONE   = 9'b100000000
    } state_t;
endpackage

@@ rtl/sorted_index_table_unit.sv @@
`timescale 1ns / 1ps
// channel | direction | ports
// s_      | in        | s_valid, s_ready, s_func[1:0], s_key[15:0]
// m_      | out       | m_valid, m_ready, m_status[1:0], m_record_number[4:0],
//         |           | m_entry_count[5:0]
// One word at a time. A search reads every held entry.
// An insert then shifts the entries below its slot down one place, then writes the new entry.
// An unused code skips the search and is answered directly.
// Synchronous active-low reset clears the entry count; table contents need no clearing.
// A finished result sits in the output register while the next word is accepted.
module sorted_index_table_unit
    import sit_pkg::*;
(
    input  logic                aclk,
    input  logic                aresetn,
    input  logic                s_valid,
    output logic                s_ready,
    input  logic [1:0]          s_func,
    input  logic [KEY_BITS-1:0] s_key,
    output logic                m_valid,
    input  logic                m_ready,
    output logic [1:0]          m_status,
    output logic [REC_W-1:0]    m_record_number,
    output logic [CNT_W-1:0]    m_entry_count
);
    state_t              state_reg, state_next;
    logic [CNT_W-1:0]    count_reg, count_next;
    logic [CNT_W-1:0]    idx_reg, idx_next;
    logic [CNT_W-1:0]    pos_reg, pos_next;
    logic                pos_set_reg, pos_set_next;
    logic                found_reg, found_next;
    entry_t              hit_reg, hit_next;
    logic [IDX_W-1:0]    slot_reg, slot_next;
    logic [1:0]          func_reg, func_next;
    logic [KEY_BITS-1:0] key_reg, key_next;
    logic [1:0]          st_reg, st_next;
    logic [REC_W-1:0]    rec_reg, rec_next;
    logic                mv_reg, mv_next;
    logic [1:0]          mst_reg, mst_next;
    logic [REC_W-1:0]    mrec_reg, mrec_next;
    logic [CNT_W-1:0]    mcnt_reg, mcnt_next;

    logic                we;
    logic [IDX_W-1:0]    waddr, raddr;
    entry_t              wdata, rdata;

    sit_ram #(.WIDTH(ENT_W), .DEPTH(DEPTH)) u_ram (
        .aclk  (aclk),
        .we    (we),
        .waddr (waddr),
        .wdata (wdata),
        .raddr (raddr),
        .rdata (rdata)
    );

    assign s_ready         = (state_reg == S_IDLE);
    assign m_valid         = mv_reg;
    assign m_status        = mst_reg;
    assign m_record_number = mrec_reg;
    assign m_entry_count   = mcnt_reg;

    // sequencer: search, then shift and write back
    always_comb begin
        state_next   = state_reg;
        count_next   = count_reg;
        idx_next     = idx_reg;
        pos_next     = pos_reg;
        pos_set_next = pos_set_reg;
        found_next   = found_reg;
        hit_next     = hit_reg;
        slot_next    = slot_reg;
        func_next    = func_reg;
        key_next     = key_reg;
        st_next      = st_reg;
        rec_next     = rec_reg;
        mv_next      = mv_reg;
        mst_next     = mst_reg;
        mrec_next    = mrec_reg;
        mcnt_next    = mcnt_reg;
        we           = 1'b0;
        waddr        = idx_reg[IDX_W-1:0];
        wdata        = rdata;
        raddr        = idx_reg[IDX_W-1:0];

        if (mv_reg && m_ready) begin
            mv_next = 1'b0;
        end

        case (state_reg)
            S_IDLE: begin
                if (s_valid) begin
                    func_next    = s_func;
                    key_next     = s_key;
                    idx_next     = '0;
                    pos_next     = count_reg;
                    pos_set_next = 1'b0;
                    found_next   = 1'b0;
                    st_next      = ST_NOT_FOUND;
                    rec_next     = '0;
                    if (!(s_func inside {FN_INSERT, FN_LOOKUP, FN_DELETE})) begin
                        state_next = S_DONE;
                    end else if (count_reg == '0) begin
                        state_next = S_DECIDE;
                    end else begin
                        state_next = S_RD;
                    end
                end
            end
            S_RD: begin
                state_next = S_CHK;
            end
            S_CHK: begin
                if (rdata.key == key_reg) begin
                    found_next = 1'b1;
                    hit_next   = rdata;
                    slot_next  = idx_reg[IDX_W-1:0];
                end
                if (!pos_set_reg && rdata.key <= key_reg) begin
                    pos_set_next = 1'b1;
                    pos_next     = idx_reg;
                end
                idx_next   = idx_reg + 1'b1;
                state_next = (idx_reg + 1'b1 == count_reg) ? S_DECIDE : S_RD;
            end
            S_DECIDE: begin
                state_next = S_DONE;
                if (func_reg == FN_INSERT) begin
                    if (found_reg) begin
                        st_next = ST_DUP;
                    end else if (count_reg == CNT_W'(DEPTH)) begin
                        st_next = ST_FULL;
                    end else begin
                        idx_next   = count_reg;
                        state_next = (count_reg == pos_reg) ? S_WRNEW : S_SHRD;
                    end
                end else if (found_reg && !hit_reg.deleted) begin
                    st_next  = ST_OK;
                    rec_next = hit_reg.rec;
                    if (func_reg == FN_DELETE) begin
                        state_next = S_WRDEL;
                    end
                end
            end
            S_SHRD: begin
                raddr      = IDX_W'(idx_reg - 1'b1);
                state_next = S_SHWR;
            end
            S_SHWR: begin
                we         = 1'b1;
                idx_next   = idx_reg - 1'b1;
                state_next = (idx_reg - 1'b1 == pos_reg) ? S_WRNEW : S_SHRD;
            end
            S_WRNEW: begin
                we          = 1'b1;
                waddr       = pos_reg[IDX_W-1:0];
                wdata.key   = key_reg;
                wdata.rec   = REC_W'(count_reg);
                wdata.deleted = 1'b0;
                st_next     = ST_OK;
                rec_next    = REC_W'(count_reg);
                count_next  = count_reg + 1'b1;
                state_next  = S_DONE;
            end
            S_WRDEL: begin
                we            = 1'b1;
                waddr         = slot_reg;
                wdata         = hit_reg;
                wdata.deleted = 1'b1;
                state_next    = S_DONE;
            end
            S_DONE: begin
                if (!mv_reg || m_ready) begin
                    mv_next    = 1'b1;
                    mst_next   = st_reg;
                    mrec_next  = rec_reg;
                    mcnt_next  = count_reg;
                    state_next = S_IDLE;
                end
            end
            default: begin
                state_next = S_IDLE;
            end
        endcase
    end

    // control state
    always_ff @(posedge aclk) begin
        if (!aresetn) begin
            state_reg <= S_IDLE;
            count_reg <= '0;
            mv_reg    <= 1'b0;
        end else begin
            state_reg <= state_next;
            count_reg <= count_next;
            mv_reg    <= mv_next;
        end
    end

    // payload and scan registers
    always_ff @(posedge aclk) begin
        idx_reg     <= idx_next;
        pos_reg     <= pos_next;
        pos_set_reg <= pos_set_next;
        found_reg   <= found_next;
        hit_reg     <= hit_next;
        slot_reg    <= slot_next;
        func_reg    <= func_next;
        key_reg     <= key_next;
        st_reg      <= st_next;
        rec_reg     <= rec_next;
        mst_reg     <= mst_next;
        mrec_reg    <= mrec_next;
        mcnt_reg    <= mcnt_next;
    end

    // count stays within the table
    assert property (@(posedge aclk) disable iff (!aresetn)
        count_reg <= CNT_W'(DEPTH))
        else $error("entry count beyond table depth");

    // a failed operation reports record zero
    assert property (@(posedge aclk) disable iff (!aresetn)
        m_valid && m_status != ST_OK |-> m_record_number == '0)
        else $error("nonzero record on failed operation");

    // count only grows by one, and only on a new-entry write
    assert property (@(posedge aclk) disable iff (!aresetn)
        count_reg != $past(count_reg) |-> $past(state_reg) == S_WRNEW)
        else $error("count changed outside insert write");

    // result register only reloads from the done state
    assert property (@(posedge aclk) disable iff (!aresetn)
        $rose(m_valid) |-> $past(state_reg) == S_DONE)
        else $error("result word without completed operation");
endmodule

@@ rtl/sit_ram.sv @@
`timescale 1ns / 1ps
module sit_ram #(
    parameter int WIDTH = 8,
    parameter int DEPTH = 32
) (
    input  logic                     aclk,
    input  logic                     we,
    input  logic [$clog2(DEPTH)-1:0] waddr,
    input  logic [WIDTH-1:0]         wdata,
    input  logic [$clog2(DEPTH)-1:0] raddr,
    output logic [WIDTH-1:0]         rdata
);
    logic [WIDTH-1:0] mem [DEPTH];

    // one write port, registered read port
    always_ff @(posedge aclk) begin
        if (we) begin
            mem[waddr] <= wdata;
        end
        rdata <= mem[raddr];
    end
endmodule

@@ verif/sorted_index_table_checker.sv @@
`timescale 1ns / 1ps
module sorted_index_table_checker
    import sit_pkg::*;
(
    input  logic                aclk,
    input  logic                aresetn,
    input  logic                s_valid,
    input  logic                s_ready,
    input  logic [1:0]          s_func,
    input  logic [KEY_BITS-1:0] s_key,
    input  logic                m_valid,
    input  logic                m_ready,
    input  logic [1:0]          m_status,
    input  logic [REC_W-1:0]    m_record_number,
    input  logic [CNT_W-1:0]    m_entry_count,
    output int                  fail_count,
    output int                  pending_results
);
    typedef struct packed {
        logic [1:0]       status;
        logic [REC_W-1:0] rec;
        logic [CNT_W-1:0] cnt;
    } answer_t;

    // shadow copy of the sorted table
    logic [KEY_BITS-1:0] tbl_key [DEPTH];
    logic [REC_W-1:0]    tbl_rec [DEPTH];
    logic                tbl_del [DEPTH];
    int                  tbl_count;
    answer_t             answers_due[$];

    assign pending_results = answers_due.size();

    // apply one word to the shadow table and return the answer it earns
    function automatic answer_t apply_word(logic [1:0] fn, logic [KEY_BITS-1:0] k);
        answer_t a;
        int slot;
        int pos;
        slot = DEPTH;
        a.status = ST_NOT_FOUND;
        a.rec = '0;
        for (int i = tbl_count - 1; i >= 0; i--)
            if (tbl_key[i] == k) slot = i;
        if (fn == FN_INSERT) begin
            if (slot < DEPTH) begin
                a.status = ST_DUP;
            end else if (tbl_count >= DEPTH) begin
                a.status = ST_FULL;
            end else begin
                pos = 0;
                while (pos < tbl_count && tbl_key[pos] > k) pos++;
                for (int i = tbl_count; i > pos; i--) begin
                    tbl_key[i] = tbl_key[i-1];
                    tbl_rec[i] = tbl_rec[i-1];
                    tbl_del[i] = tbl_del[i-1];
                end
                tbl_key[pos] = k;
                tbl_rec[pos] = REC_W'(tbl_count);
                tbl_del[pos] = 1'b0;
                a.rec = REC_W'(tbl_count);
                tbl_count++;
                a.status = ST_OK;
            end
        end else if (fn == FN_LOOKUP || fn == FN_DELETE) begin
            if (slot < DEPTH && !tbl_del[slot]) begin
                if (fn == FN_DELETE) tbl_del[slot] = 1'b1;
                a.rec = tbl_rec[slot];
                a.status = ST_OK;
            end
        end
        a.cnt = CNT_W'(tbl_count);
        return a;
    endfunction

    // predict on accepted input words, compare on accepted result words
    always @(posedge aclk) begin
        answer_t want;
        int errs;
        errs = 0;
        if (!aresetn) begin
            tbl_count = 0;
            fail_count <= 0;
            answers_due.delete();
        end else begin
            if (m_valid && m_ready) begin
                if (answers_due.size() == 0) begin
                    $error("result word with nothing expected");
                    errs++;
                end else begin
                    want = answers_due.pop_front();
                    if (m_status !== want.status) begin
                        $error("status expected %0d actual %0d", want.status, m_status);
                        errs++;
                    end
                    if (m_record_number !== want.rec) begin
                        $error("record_number expected %0d actual %0d", want.rec,
                            m_record_number);
                        errs++;
                    end
                    if (m_entry_count !== want.cnt) begin
                        $error("entry_count expected %0d actual %0d", want.cnt,
                            m_entry_count);
                        errs++;
                    end
                end
            end
            if (s_valid && s_ready)
                answers_due.push_back(apply_word(s_func, s_key));
            if (errs != 0)
                fail_count <= fail_count + errs;
        end
    end
endmodule

@@ verif/sorted_index_table_unit_tb.sv @@
`timescale 1ns / 1ps
module sorted_index_table_unit_tb;
    import sit_pkg::*;

    localparam int RANDOM_WORDS = 1250;
    localparam longint CYCLE_LIMIT = 2000000;

    logic                aclk;
    logic                aresetn;
    logic                s_valid;
    logic                s_ready;
    logic [1:0]          s_func;
    logic [KEY_BITS-1:0] s_key;
    logic                m_valid;
    logic                m_ready;
    logic [1:0]          m_status;
    logic [REC_W-1:0]    m_record_number;
    logic [CNT_W-1:0]    m_entry_count;
    int                  fail_count;
    int                  pending_results;
    longint              cycle_count;
    logic                long_hold;
    int                  words_sent;
    logic [KEY_BITS-1:0] recent_keys[$];

    sorted_index_table_unit uut (.*);

    sorted_index_table_checker checker_i (.*);

    initial begin
        aclk = 1'b0;
        forever #6 aclk = ~aclk;
    end

    // run limit
    initial cycle_count = 0;
    always @(posedge aclk) begin
        cycle_count <= cycle_count + 1;
        if (cycle_count > CYCLE_LIMIT) begin
            $display("Regression FAIL");
            $finish;
        end
    end

    // receiver: random stalls, plus one long hold-off
    initial begin
        int gap;
        m_ready = 1'b0;
        forever begin
            @(posedge aclk);
            if (long_hold) begin
                m_ready <= 1'b0;
                repeat (400) @(posedge aclk);
                long_hold = 1'b0;
            end
            gap = ($urandom_range(0, 3) == 0) ? 0 : $urandom_range(0, 12);
            if (gap > 0) begin
                m_ready <= 1'b0;
                repeat (gap) @(posedge aclk);
            end
            m_ready <= 1'b1;
            do @(posedge aclk); while (!(m_valid && m_ready));
            // ready is set at random into the next draw, and lowered for any gap
            m_ready <= ($urandom_range(0, 1) == 0);
        end
    end

    task automatic send_word(input logic [1:0] fn, input logic [KEY_BITS-1:0] k,
                             input bit use_gap);
        int gap;
        gap = use_gap ? $urandom_range(0, 12) : 0;
        if (gap > 0) begin
            s_valid <= 1'b0;
            repeat (gap) @(posedge aclk);
        end
        s_valid <= 1'b1;
        s_func  <= fn;
        s_key   <= k;
        do @(posedge aclk); while (!(s_valid && s_ready));
        words_sent++;
        if (fn == FN_INSERT && recent_keys.size() < 64) recent_keys.push_back(k);
    endtask

    function automatic logic [KEY_BITS-1:0] pick_key();
        // mostly reuse known keys so lookups and deletes hit
        if (recent_keys.size() > 0 && $urandom_range(0, 2) != 0)
            return recent_keys[$urandom_range(0, recent_keys.size() - 1)];
        return KEY_BITS'($urandom());
    endfunction

    initial begin
        logic [1:0] fn;
        int roll;
        aresetn = 1'b0;
        s_valid = 1'b0;
        s_func = FN_INSERT;
        s_key = '0;
        long_hold = 1'b0;
        words_sent = 0;
        repeat (5) @(posedge aclk);
        aresetn <= 1'b1;
        @(posedge aclk);

        // directed: empty table cases, key extremes, duplicates, tombstones
        send_word(FN_LOOKUP, 16'h0000, 1'b0);
        send_word(FN_DELETE, 16'hffff, 1'b0);
        send_word(FN_UNUSED, 16'h1234, 1'b0);
        send_word(FN_INSERT, 16'h0000, 1'b0);
        send_word(FN_INSERT, 16'hffff, 1'b0);
        send_word(FN_INSERT, 16'h5555, 1'b0);
        send_word(FN_INSERT, 16'haaaa, 1'b0);
        send_word(FN_INSERT, 16'h5555, 1'b0);
        send_word(FN_LOOKUP, 16'hffff, 1'b0);
        send_word(FN_LOOKUP, 16'h0000, 1'b0);
        send_word(FN_DELETE, 16'haaaa, 1'b0);
        send_word(FN_LOOKUP, 16'haaaa, 1'b0);
        send_word(FN_DELETE, 16'haaaa, 1'b0);
        send_word(FN_INSERT, 16'haaaa, 1'b0);
        send_word(FN_UNUSED, 16'hffff, 1'b0);
        send_word(FN_LOOKUP, 16'h1111, 1'b0);
        // fill to full, then one more new key and a duplicate
        for (int i = 0; i < DEPTH; i++)
            send_word(FN_INSERT, KEY_BITS'(i * 997 + 7), 1'b0);
        send_word(FN_INSERT, 16'h7777, 1'b0);
        send_word(FN_INSERT, 16'hffff, 1'b0);
        send_word(FN_LOOKUP, KEY_BITS'(7), 1'b0);

        // full table: random mix of lookups, deletes, rejected inserts
        // the table never empties, so deep behavior is exercised in this state
        long_hold = 1'b1;
        for (int n = 0; n < RANDOM_WORDS; n++) begin
            roll = $urandom_range(0, 19);
            if (roll < 8) fn = FN_LOOKUP;
            else if (roll < 14) fn = FN_DELETE;
            else if (roll < 19) fn = FN_INSERT;
            else fn = FN_UNUSED;
            if ($urandom_range(0, 1) == 0)
                send_word(fn, KEY_BITS'(($urandom_range(0, DEPTH - 1)) * 997 + 7), 1'b1);
            else
                send_word(fn, pick_key(), ($urandom_range(0, 4) != 0));
            if (n == RANDOM_WORDS / 2) begin
                // sender pause until drained
                s_valid <= 1'b0;
                @(posedge aclk);
                while (pending_results != 0) @(posedge aclk);
            end
        end

        s_valid <= 1'b0;
        @(posedge aclk);
        while (pending_results != 0) @(posedge aclk);
        repeat (200) @(posedge aclk);
        $display("covered %0d words: empty, partial and full table, duplicates,", words_sent);
        $display("tombstone deletes, unused opcode, long output stall and drain pause");
        if (fail_count == 0) begin
            $display("Regression PASS");
        end else begin
            $display("Regression FAIL");
        end
        $finish;
    end
endmodule
